[rtl/iprt_pkg.sv]
// Shared types and constants for the IPv4 route table lookup block.
`timescale 1ns / 1ps
package iprt_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [15:0] IPV4_TYPE = 16'h0800;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] ALL_ZEROS = 32'h0000_0000;

    localparam logic [2:0] CFG_LOCAL_MAC = 3'd0;
    localparam logic [2:0] CFG_LOCAL_IP_A = 3'd1;
    localparam logic [2:0] CFG_LOCAL_MASK_A = 3'd2;
    localparam logic [2:0] CFG_LOCAL_IP_B = 3'd3;
    localparam logic [2:0] CFG_LOCAL_MASK_B = 3'd4;

    localparam logic [3:0] ST_DIRECT = 4'd0;
    localparam logic [3:0] ST_GATEWAY = 4'd1;
    localparam logic [3:0] ST_NOROUTE = 4'd2;
    localparam logic [3:0] ST_LOCAL = 4'd3;
    localparam logic [3:0] ST_IGNORED = 4'd4;
    localparam logic [3:0] ST_ADDED = 4'd5;
    localparam logic [3:0] ST_UPDATED = 4'd6;
    localparam logic [3:0] ST_DELETED = 4'd7;
    localparam logic [3:0] ST_NOTFOUND = 4'd8;
    localparam logic [3:0] ST_PROTECTED = 4'd9;
    localparam logic [3:0] ST_FULL = 4'd10;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_ADD,
        OP_DELETE,
        OP_DONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  status;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
    } cmd_t;
endpackage

[rtl/iprt_front.sv]
// Front end: accepts words, applies the local filters and queues classified commands.
`timescale 1ns / 1ps
module iprt_front
    import iprt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] dest_ip,
    input  logic [31:0] route_mask,
    input  logic [31:0] gateway_ip,
    input  logic [47:0] source_mac,
    input  logic [15:0] ether_type,
    input  logic [47:0] local_mac,
    input  logic [31:0] local_ip_a,
    input  logic [31:0] local_mask_a,
    input  logic [31:0] local_ip_b,
    input  logic [31:0] local_mask_b,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] CNT_QD = (PTR_W + 1)'(QUEUE_DEPTH);

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;
    cmd_t             cls;
    logic             push, pop;

    always_comb
    begin
        cls.dest = dest_ip;
        cls.mask = route_mask;
        cls.gateway = gateway_ip;
        cls.status = ST_IGNORED;
        cls.op = OP_DONE;
        case (action)
            ACT_LOOKUP:
            begin
                if (source_mac == local_mac || ether_type != IPV4_TYPE)
                begin
                    cls.status = ST_IGNORED;
                end
                else if (dest_ip == local_ip_a || dest_ip == local_ip_b
                         || (dest_ip & local_mask_a) == (ALL_ONES & local_mask_a)
                         || (dest_ip & local_mask_b) == (ALL_ONES & local_mask_b))
                begin
                    cls.status = ST_LOCAL;
                end
                else
                begin
                    cls.op = OP_LOOKUP;
                end
            end
            ACT_ADD:
            begin
                cls.op = OP_ADD;
            end
            ACT_DELETE:
            begin
                if (dest_ip == (local_ip_a & local_mask_a)
                    || dest_ip == (local_ip_b & local_mask_b))
                begin
                    cls.status = ST_PROTECTED;
                end
                else
                begin
                    cls.op = OP_DELETE;
                end
            end
            default:
            begin
                cls.status = ST_IGNORED;
            end
        endcase
    end

    assign in_ready = (fill_reg != CNT_QD);
    assign push = in_valid && in_ready;
    assign cmd_valid = (fill_reg != '0);
    assign pop = cmd_valid && cmd_ready;
    assign cmd = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next = fill_reg + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule

[rtl/iprt_back.sv]
// Back end: the sorted route cells, with match, shift insertion and removal.
`timescale 1ns / 1ps
module iprt_back
    import iprt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        status,
    output logic [31:0]       next_hop_ip,
    output logic [4:0]        entry_count
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY,
        S_OUT
    } state_t;

    state_t             state_reg;
    cmd_t               cur_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        dest_reg [TABLE_DEPTH];
    logic [31:0]        mask_reg [TABLE_DEPTH];
    logic [31:0]        gw_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_reg, exact_reg, less_reg;
    logic [3:0]         status_reg;
    logic [31:0]        hop_reg;

    logic [TABLE_DEPTH-1:0] live, hit, exact, less;
    logic [TABLE_DEPTH-1:0] first_hit, first_exact, before_pos;
    logic               any_hit, any_exact, upd;
    logic [31:0]        hit_gw;
    logic               full;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            live[i] = (CNT_W'(i) < count_reg);
            hit[i] = live[i] && ((cur_reg.dest & mask_reg[i]) == dest_reg[i]);
            exact[i] = live[i] && dest_reg[i] == cur_reg.dest
                       && mask_reg[i] == cur_reg.mask;
            less[i] = live[i] && (mask_reg[i] < cur_reg.mask);
        end
    end

    // Priority picks, one-hot over the registered match vectors.
    always_comb
    begin
        logic seen_h, seen_e, seen_l;
        seen_h = 1'b0;
        seen_e = 1'b0;
        seen_l = 1'b0;
        hit_gw = '0;
        upd = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            first_hit[i] = hit_reg[i] && !seen_h;
            if (first_hit[i])
            begin
                hit_gw = gw_reg[i];
            end
            seen_h = seen_h | hit_reg[i];
            // An update counts only if no smaller mask comes first.
            first_exact[i] = exact_reg[i] && !seen_e && !seen_l;
            upd = upd | first_exact[i];
            seen_e = seen_e | exact_reg[i];
            seen_l = seen_l | less_reg[i];
            before_pos[i] = !seen_l;
        end
        any_hit = seen_h;
        any_exact = seen_e;
    end

    // True when the entry being removed sits at or before position p.
    function automatic logic at_or_after(input int p);
        logic r;
        r = 1'b0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            if (j <= p)
            begin
                r = r | exact_reg[j];
            end
        end
        return r;
    endfunction

    assign full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status = status_reg;
    assign next_hop_ip = hop_reg;
    assign entry_count = 5'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= (cmd.op == OP_DONE) ? S_OUT : S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    state_reg <= S_OUT;
                    if (cur_reg.op == OP_ADD && !upd && !full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    else if (cur_reg.op == OP_DELETE && any_exact)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            cur_reg <= cmd;
            status_reg <= cmd.status;
            hop_reg <= ALL_ZEROS;
        end
        if (state_reg == S_MATCH)
        begin
            hit_reg <= hit;
            exact_reg <= exact;
            less_reg <= less;
        end
        if (state_reg == S_APPLY)
        begin
            case (cur_reg.op)
                OP_LOOKUP:
                begin
                    if (!any_hit)
                    begin
                        status_reg <= ST_NOROUTE;
                    end
                    else if (hit_gw == ALL_ZEROS)
                    begin
                        status_reg <= ST_DIRECT;
                        hop_reg <= cur_reg.dest;
                    end
                    else
                    begin
                        status_reg <= ST_GATEWAY;
                        hop_reg <= hit_gw;
                    end
                end
                OP_ADD:
                begin
                    if (upd)
                    begin
                        status_reg <= ST_UPDATED;
                        for (int i = 0; i < TABLE_DEPTH; i++)
                        begin
                            if (first_exact[i])
                            begin
                                gw_reg[i] <= cur_reg.gateway;
                            end
                        end
                    end
                    else if (full)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        status_reg <= ST_ADDED;
                        for (int i = 0; i < TABLE_DEPTH; i++)
                        begin
                            if (!before_pos[i])
                            begin
                                if (i == 0 || !before_pos[(i == 0) ? 0 : i - 1])
                                begin
                                    if (i > 0)
                                    begin
                                        dest_reg[i] <= dest_reg[(i == 0) ? 0 : i - 1];
                                        mask_reg[i] <= mask_reg[(i == 0) ? 0 : i - 1];
                                        gw_reg[i] <= gw_reg[(i == 0) ? 0 : i - 1];
                                    end
                                end
                                if (i == 0 || before_pos[(i == 0) ? 0 : i - 1])
                                begin
                                    dest_reg[i] <= cur_reg.dest;
                                    mask_reg[i] <= cur_reg.mask;
                                    gw_reg[i] <= cur_reg.gateway;
                                end
                            end
                            else if (CNT_W'(i) == count_reg)
                            begin
                                dest_reg[i] <= cur_reg.dest;
                                mask_reg[i] <= cur_reg.mask;
                                gw_reg[i] <= cur_reg.gateway;
                            end
                        end
                    end
                end
                OP_DELETE:
                begin
                    if (any_exact)
                    begin
                        status_reg <= ST_DELETED;
                        for (int i = 0; i < TABLE_DEPTH - 1; i++)
                        begin
                            if (exact_reg[i] || (i > 0 && at_or_after(i)))
                            begin
                                dest_reg[i] <= dest_reg[i + 1];
                                mask_reg[i] <= mask_reg[i + 1];
                                gw_reg[i] <= gw_reg[i + 1];
                            end
                        end
                    end
                    else
                    begin
                        status_reg <= ST_NOTFOUND;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule

[rtl/ipv4_route_table_lookup.sv]
// Top level of the IPv4 route table lookup block.
`timescale 1ns / 1ps
// Routes are held in sixteen register cells sorted by descending mask, so the
// first matching cell is the longest prefix. Each word yields one result word.
// Filtered lookups, protected deletes and unused actions go from acceptance
// straight to the output step; table operations pass through the match, apply
// and output steps of the back-end sequencer. A two-word command queue lets the
// front end accept further words while the back end works.
module ipv4_route_table_lookup
    import iprt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] dest_ip,
    input  logic [31:0] route_mask,
    input  logic [31:0] gateway_ip,
    input  logic [47:0] source_mac,
    input  logic [15:0] ether_type,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [31:0] next_hop_ip,
    output logic [4:0]  entry_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    logic [47:0] local_mac_reg;
    logic [31:0] local_ip_a_reg, local_mask_a_reg, local_ip_b_reg, local_mask_b_reg;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac_reg <= '0;
            local_ip_a_reg <= '0;
            local_mask_a_reg <= '0;
            local_ip_b_reg <= '0;
            local_mask_b_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOCAL_MAC: local_mac_reg <= cfg_data;
                CFG_LOCAL_IP_A: local_ip_a_reg <= cfg_data[31:0];
                CFG_LOCAL_MASK_A: local_mask_a_reg <= cfg_data[31:0];
                CFG_LOCAL_IP_B: local_ip_b_reg <= cfg_data[31:0];
                CFG_LOCAL_MASK_B: local_mask_b_reg <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    iprt_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .dest_ip(dest_ip), .route_mask(route_mask),
        .gateway_ip(gateway_ip), .source_mac(source_mac), .ether_type(ether_type),
        .local_mac(local_mac_reg), .local_ip_a(local_ip_a_reg),
        .local_mask_a(local_mask_a_reg), .local_ip_b(local_ip_b_reg),
        .local_mask_b(local_mask_b_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    iprt_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .next_hop_ip(next_hop_ip), .entry_count(entry_count)
    );
endmodule

[tb/tb_ipv4_route_table_lookup.sv]
// Self-checking testbench for the IPv4 route table lookup block.
`timescale 1ns / 1ps
module tb_ipv4_route_table_lookup;
    import iprt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [31:0] dest_ip;
    logic [31:0] route_mask;
    logic [31:0] gateway_ip;
    logic [47:0] source_mac;
    logic [15:0] ether_type;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  status;
    logic [31:0] next_hop_ip;
    logic [4:0]  entry_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] hop;
        logic [4:0]  count;
    } route_reply_t;

    ipv4_route_table_lookup dut (.*);

    logic [47:0] my_mac;
    logic [31:0] ip_a, mask_a, ip_b, mask_b;
    logic [31:0] tbl_dest [TABLE_DEPTH];
    logic [31:0] tbl_mask [TABLE_DEPTH];
    logic [31:0] tbl_gw [TABLE_DEPTH];
    int          tbl_count;

    route_reply_t pending_replies[$];
    int  fail_count;
    int  idle_pct;
    int  stall_pct;
    int  items_sent;
    int  replies_seen;
    int  quiet_cycles;
    logic [31:0] prefix_pool [8];
    logic [31:0] mask_pool [8];

    localparam int WATCHDOG = 20000;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic route_reply_t route_predict(logic [1:0] act, logic [31:0] d,
                                                   logic [31:0] m, logic [31:0] g,
                                                   logic [47:0] smac, logic [15:0] et);
        route_reply_t r;
        int i;
        int k;
        bit done;
        r.status = ST_IGNORED;
        r.hop = ALL_ZEROS;
        done = 0;
        if (act == ACT_LOOKUP)
        begin
            if (smac == my_mac || et != IPV4_TYPE)
                r.status = ST_IGNORED;
            else if (d == ip_a || d == ip_b || (d & mask_a) == mask_a
                     || (d & mask_b) == mask_b)
                r.status = ST_LOCAL;
            else
            begin
                r.status = ST_NOROUTE;
                for (i = 0; i < tbl_count && !done; i++)
                    if ((d & tbl_mask[i]) == tbl_dest[i])
                    begin
                        done = 1;
                        r.status = (tbl_gw[i] == 0) ? ST_DIRECT : ST_GATEWAY;
                        r.hop = (tbl_gw[i] == 0) ? d : tbl_gw[i];
                    end
            end
        end
        else if (act == ACT_ADD)
        begin
            for (i = 0; i < tbl_count && !done; i++)
            begin
                if (tbl_dest[i] == d && tbl_mask[i] == m)
                begin
                    tbl_gw[i] = g;
                    r.status = ST_UPDATED;
                    done = 1;
                end
                else if (tbl_mask[i] < m)
                    break;
            end
            if (!done)
            begin
                if (tbl_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (k = tbl_count; k > i; k--)
                    begin
                        tbl_dest[k] = tbl_dest[k - 1];
                        tbl_mask[k] = tbl_mask[k - 1];
                        tbl_gw[k] = tbl_gw[k - 1];
                    end
                    tbl_dest[i] = d;
                    tbl_mask[i] = m;
                    tbl_gw[i] = g;
                    tbl_count++;
                    r.status = ST_ADDED;
                end
            end
        end
        else if (act == ACT_DELETE)
        begin
            if (d == (ip_a & mask_a) || d == (ip_b & mask_b))
                r.status = ST_PROTECTED;
            else
            begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < tbl_count && !done; i++)
                    if (tbl_dest[i] == d && tbl_mask[i] == m)
                    begin
                        for (k = i; k + 1 < tbl_count; k++)
                        begin
                            tbl_dest[k] = tbl_dest[k + 1];
                            tbl_mask[k] = tbl_mask[k + 1];
                            tbl_gw[k] = tbl_gw[k + 1];
                        end
                        tbl_count--;
                        r.status = ST_DELETED;
                        done = 1;
                    end
            end
        end
        r.count = tbl_count[4:0];
        return r;
    endfunction

    // The valid line stays high after acceptance until the next call or drain.
    task automatic send_word(logic [1:0] act, logic [31:0] d, logic [31:0] m,
                             logic [31:0] g, logic [47:0] smac, logic [15:0] et);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        dest_ip <= d;
        route_mask <= m;
        gateway_ip <= g;
        source_mac <= smac;
        ether_type <= et;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_replies.insert(pending_replies.size(),
                               route_predict(act, d, m, g, smac, et));
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LOCAL_MAC: my_mac = val;
            CFG_LOCAL_IP_A: ip_a = val[31:0];
            CFG_LOCAL_MASK_A: mask_a = val[31:0];
            CFG_LOCAL_IP_B: ip_b = val[31:0];
            default: mask_b = val[31:0];
        endcase
    endtask

    task automatic set_locals(logic [47:0] mac, logic [31:0] a, logic [31:0] ma,
                              logic [31:0] b, logic [31:0] mb);
        write_reg(CFG_LOCAL_MAC, mac);
        write_reg(CFG_LOCAL_IP_A, {16'h0, a});
        write_reg(CFG_LOCAL_MASK_A, {16'h0, ma});
        write_reg(CFG_LOCAL_IP_B, {16'h0, b});
        write_reg(CFG_LOCAL_MASK_B, {16'h0, mb});
        cfg_valid <= 1'b0;
    endtask

    task automatic lookup(logic [31:0] d);
        send_word(ACT_LOOKUP, d, $urandom, $urandom, 48'({$urandom, $urandom}) | 48'h1,
                  IPV4_TYPE);
    endtask

    task automatic test_directed();
        int i;
        // Zero local masks make every lookup local; reset MAC of zero is ignored.
        send_word(ACT_LOOKUP, 32'h0a000001, 0, 0, 48'h0, IPV4_TYPE);
        lookup(32'h0a000001);
        send_word(ACT_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
        drain();
        set_locals(48'h0200_0000_0001, 32'hc0a80101, 32'hffffff00,
                   32'h0a000001, 32'hff000000);
        send_word(ACT_LOOKUP, 32'h08080808, 0, 0, 48'h0200_0000_0001, IPV4_TYPE);
        send_word(ACT_LOOKUP, 32'h08080808, 0, 0, 48'h5, 16'h86dd);
        lookup(32'hc0a80101);
        lookup(32'hc0a801ff);
        lookup(32'h08080808);
        send_word(ACT_ADD, 32'hc0a80100, 32'hffffff00, 0, 0, 0);
        send_word(ACT_ADD, 32'h0a000000, 32'hff000000, 0, 0, 0);
        send_word(ACT_ADD, ALL_ZEROS, ALL_ZEROS, 32'hc0a801fe, 0, 0);
        send_word(ACT_ADD, 32'h08080800, 32'hffffff00, 32'h0a0000fe, 0, 0);
        send_word(ACT_ADD, ALL_ZEROS, ALL_ZEROS, 32'hc0a801fd, 0, 0);
        lookup(32'h08080808);
        lookup(32'h09090909);
        lookup(32'hc0a80105);
        send_word(ACT_DELETE, 32'hc0a80100, 32'hffff0000, 0, 0, 0);
        send_word(ACT_DELETE, 32'h01020300, 32'hffffff00, 0, 0, 0);
        send_word(ACT_DELETE, 32'h08080800, 32'hffffff00, 0, 0, 0);
        for (i = 0; i < 16; i++)
            send_word(ACT_ADD, i << 4, ALL_ONES << i, i, 0, 0);
        send_word(ACT_ADD, ALL_ONES, ALL_ONES, 1, 0, 0);
        send_word(ACT_ADD, ALL_ZEROS, ALL_ZEROS, 0, 0, 0);
        lookup(32'h00000011);
        drain();
    endtask

    task automatic test_random(int n, int idle, int stall);
        int j;
        int p;
        logic [1:0] act;
        logic [31:0] d;
        idle_pct = idle;
        stall_pct = stall;
        for (j = 0; j < n; j++)
        begin
            p = $urandom_range(7);
            d = $urandom;
            case ($urandom_range(9))
                0, 1, 2: act = ACT_ADD;
                3, 4: act = ACT_DELETE;
                5: act = ACT_UNUSED;
                default: act = ACT_LOOKUP;
            endcase
            if (act == ACT_LOOKUP)
            begin
                if ($urandom_range(3) != 0)
                    d = prefix_pool[p] | (d & ~mask_pool[p]);
                if ($urandom_range(15) == 0)
                    d = (d & 1) ? ip_a : ip_b | ~mask_b;
                send_word(act, d, $urandom, $urandom,
                          ($urandom_range(19) == 0) ? my_mac
                                                    : 48'({$urandom, $urandom}),
                          ($urandom_range(9) == 0) ? 16'($urandom) : IPV4_TYPE);
            end
            else if ($urandom_range(7) == 0)
                send_word(act, d, $urandom, $urandom, 48'({$urandom, $urandom}),
                          16'($urandom));
            else
                send_word(act, prefix_pool[p], mask_pool[p],
                          ($urandom_range(2) == 0) ? ALL_ZEROS : 32'($urandom), 0, 0);
        end
        drain();
    endtask

    task automatic new_pools();
        int p;
        for (p = 0; p < 8; p++)
        begin
            mask_pool[p] = ALL_ONES << $urandom_range(32);
            if ($urandom_range(7) == 0)
                mask_pool[p] = ALL_ZEROS;
            prefix_pool[p] = $urandom & mask_pool[p];
        end
    endtask

    always @(posedge clk)
    begin
        route_reply_t exp;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                replies_seen++;
                if (pending_replies.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp = pending_replies.pop_front();
                    if (status !== exp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp.status, status);
                        fail_count++;
                    end
                    if (next_hop_ip !== exp.hop)
                    begin
                        $error("next_hop_ip: expected %h, got %h", exp.hop, next_hop_ip);
                        fail_count++;
                    end
                    if (entry_count !== exp.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", exp.count,
                               entry_count);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > WATCHDOG)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        action = ACT_LOOKUP;
        dest_ip = 0;
        route_mask = 0;
        gateway_ip = 0;
        source_mac = 0;
        ether_type = 0;
        cfg_index = CFG_LOCAL_MAC;
        cfg_data = 0;
        my_mac = 0;
        ip_a = 0;
        mask_a = 0;
        ip_b = 0;
        mask_b = 0;
        tbl_count = 0;
        fail_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        replies_seen = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        new_pools();
        test_random(450, 0, 0);
        set_locals(48'hFFFF_FFFF_FFFF, ALL_ONES, ALL_ONES, ALL_ZEROS, ALL_ONES);
        new_pools();
        test_random(450, 73, 0);
        set_locals(48'({$urandom, $urandom}), $urandom, 32'hfffffff0, $urandom,
                   32'hffff0000);
        new_pools();
        test_random(450, 0, 73);
        new_pools();
        test_random(400, 13, 13);
        $display("Sent %0d words through lookup, add, delete and unused actions,",
                 items_sent);
        $display("under four local settings and four idling mixes; %0d results checked.",
                 replies_seen);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
